// ----- src/tkst_pkg.sv -----
package tkst_pkg;

    // Default sizes of the table
    localparam int DEF_TABLE_DEPTH = 10;
    localparam int DEF_NUM_BOARDS  = 8;

    // Floor reported as top score
    localparam logic [23:0] TOP_FLOOR = 24'd10000;

    // Command codes (code 3 behaves as a query)
    localparam logic [1:0] CMD_QUERY  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_SUBMIT = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  board_index;
        logic [23:0] new_score;
        logic [7:0]  new_level;
        logic [15:0] lines_cleared;
        logic [15:0] date_code;
    } t_in_item;

    typedef struct packed {
        logic        qualifies;
        logic [23:0] top_score;
        logic        inserted;
        logic [3:0]  insert_rank;
        logic [3:0]  entry_count;
    } t_out_item;

    // One stored entry, 64 bits
    typedef struct packed {
        logic [23:0] score;
        logic [7:0]  level;
        logic [15:0] lines;
        logic [15:0] date;
    } t_entry;

    // Controls from the sequencer to every cell
    typedef struct packed {
        logic rd;
        logic wr;
    } t_cell_ctl;

    // Status a cell hands to its right neighbor and to the sequencer
    typedef struct packed {
        logic ge;     // stored entry valid and scores at or above the new one
        logic place;  // new entry lands in this cell
    } t_cell_stat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } t_state;

    // Board index wrapped into the number of boards (at most 8 steps on 3 bits)
    function automatic logic [2:0] board_wrap(input logic [2:0] idx, input int nb);
        int v;
        v = int'(idx);
        for (int k = 0; k < 8; k++) begin
            if (v >= nb) begin
                v = v - nb;
            end
        end
        return v[2:0];
    endfunction

endpackage

// ----- src/tkst_cell.sv -----
// One rank position: holds that position of every board and takes part in
// the shift that opens a slot for a new entry.
module tkst_cell #(
    parameter int IDX         = 0,
    parameter int TABLE_DEPTH = tkst_pkg::DEF_TABLE_DEPTH,
    parameter int NUM_BOARDS  = tkst_pkg::DEF_NUM_BOARDS,
    localparam int AW = (NUM_BOARDS > 1) ? $clog2(NUM_BOARDS) : 1,
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                 i_clk,
    input  tkst_pkg::t_cell_ctl  i_ctl,
    input  logic [AW-1:0]        i_addr,
    input  logic [CW-1:0]        i_cnt,
    input  tkst_pkg::t_entry     i_new_ent,
    input  tkst_pkg::t_entry     i_prev_ent,
    input  logic                 i_prev_ge,
    output tkst_pkg::t_entry     o_ent,
    output tkst_pkg::t_cell_stat o_stat
);

    tkst_pkg::t_entry r_mem [NUM_BOARDS];
    tkst_pkg::t_entry r_rd_ent;
    logic             w_ge;
    logic             w_place;

    // Registered read of this position for the selected board
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rd_ent <= r_mem[i_addr];
        end
    end

    // Keep, take the new entry, or take the left neighbor's entry
    assign w_ge    = (CW'(IDX) < i_cnt) && (r_rd_ent.score >= i_new_ent.score);
    assign w_place = !w_ge && ((IDX == 0) ? 1'b1 : i_prev_ge);

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && !w_ge) begin
            r_mem[i_addr] <= w_place ? i_new_ent : i_prev_ent;
        end
    end

    assign o_ent        = r_rd_ent;
    assign o_stat.ge    = w_ge;
    assign o_stat.place = w_place;

endmodule

// ----- src/top_k_score_table.sv -----
// Top-k score table: NUM_BOARDS leaderboards of up to TABLE_DEPTH entries,
// each kept sorted by score, highest first, ties placed after older entries.
// Each item gives one result. It is accepted in the idle state; a read step
// reads the selected board from the row of rank cells (each cell owns one rank
// position of every board in a small memory); in an execute step, held while
// the output stalls, all cells compare in parallel, shift right by one past
// the insertion point and write back. A new item is accepted once the previous
// result sits in the output register, so items go one at a time. All boards
// are empty after reset; no clearing pass is needed.
module top_k_score_table #(
    parameter int TABLE_DEPTH = tkst_pkg::DEF_TABLE_DEPTH,
    parameter int NUM_BOARDS  = tkst_pkg::DEF_NUM_BOARDS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tkst_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tkst_pkg::t_out_item o_out_item
);

    localparam int AW = (NUM_BOARDS > 1) ? $clog2(NUM_BOARDS) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    tkst_pkg::t_state    r_state, n_state;
    tkst_pkg::t_in_item  r_item;
    logic [AW-1:0]       r_addr;
    logic [CW-1:0]       r_cnt_mem [NUM_BOARDS];
    logic [NUM_BOARDS-1:0] r_cnt_vld;
    logic [CW-1:0]       r_cnt_rd;
    logic                r_vld_rd;
    logic                r_out_vld, n_out_vld;
    tkst_pkg::t_out_item r_out_item, n_out_item;

    tkst_pkg::t_cell_ctl  w_ctl;
    logic                 w_in_stall;
    logic                 w_go;
    tkst_pkg::t_entry     w_new_ent;
    tkst_pkg::t_entry     w_ent  [TABLE_DEPTH];
    tkst_pkg::t_cell_stat w_stat [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_place;
    logic [CW-1:0]        w_cnt;
    logic                 w_qual;
    logic                 w_do_ins;
    logic                 w_ins;
    logic [CW-1:0]        w_rank_enc;
    logic [CW-1:0]        w_rank;
    logic [CW-1:0]        w_new_cnt;
    logic [23:0]          w_top0;
    tkst_pkg::t_out_item  w_res;

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tkst_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tkst_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = tkst_pkg::ST_READ;
                end
            end
            tkst_pkg::ST_READ: begin
                n_state = tkst_pkg::ST_EXEC;
            end
            tkst_pkg::ST_EXEC: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_state = tkst_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tkst_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        w_in_stall = 1'b1;
        w_ctl      = '0;
        w_go       = 1'b0;
        case (r_state)
            tkst_pkg::ST_IDLE: begin
                w_in_stall = 1'b0;
            end
            tkst_pkg::ST_READ: begin
                w_ctl.rd = 1'b1;
            end
            tkst_pkg::ST_EXEC: begin
                w_go     = !r_out_vld || !i_out_stall;
                w_ctl.wr = w_go && w_do_ins;
            end
            default: begin
                w_in_stall = 1'b1;
            end
        endcase
    end

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (!w_in_stall && i_in_valid) begin
            r_item <= i_in_item;
            r_addr <= AW'(tkst_pkg::board_wrap(i_in_item.board_index, NUM_BOARDS));
        end
    end

    // Entry counts: memory plus a written flag per board
    always_ff @(posedge i_clk) begin
        if (w_ctl.rd) begin
            r_cnt_rd <= r_cnt_mem[r_addr];
        end
        if (w_go) begin
            r_cnt_mem[r_addr] <= w_new_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
            r_vld_rd  <= 1'b0;
        end else begin
            if (w_ctl.rd) begin
                r_vld_rd <= r_cnt_vld[r_addr];
            end
            if (w_go) begin
                r_cnt_vld[r_addr] <= 1'b1;
            end
        end
    end

    assign w_new_ent.score = r_item.new_score;
    assign w_new_ent.level = r_item.new_level;
    assign w_new_ent.lines = r_item.lines_cleared;
    assign w_new_ent.date  = r_item.date_code;

    // Row of rank cells, each fed by its left neighbor
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            tkst_cell #(
                .IDX         (g),
                .TABLE_DEPTH (TABLE_DEPTH),
                .NUM_BOARDS  (NUM_BOARDS)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_addr     (r_addr),
                .i_cnt      (w_cnt),
                .i_new_ent  (w_new_ent),
                .i_prev_ent (w_new_ent),
                .i_prev_ge  (1'b0),
                .o_ent      (w_ent[g]),
                .o_stat     (w_stat[g])
            );
        end else begin : g_rest
            tkst_cell #(
                .IDX         (g),
                .TABLE_DEPTH (TABLE_DEPTH),
                .NUM_BOARDS  (NUM_BOARDS)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_addr     (r_addr),
                .i_cnt      (w_cnt),
                .i_new_ent  (w_new_ent),
                .i_prev_ent (w_ent[g-1]),
                .i_prev_ge  (w_stat[g-1].ge),
                .o_ent      (w_ent[g]),
                .o_stat     (w_stat[g])
            );
        end
        assign w_place[g] = w_stat[g].place;
    end

    // Decision and result
    assign w_cnt    = r_vld_rd ? r_cnt_rd : '0;
    assign w_qual   = (w_cnt < CW'(TABLE_DEPTH)) ||
                      (r_item.new_score > w_ent[TABLE_DEPTH-1].score);
    assign w_do_ins = (r_item.command == tkst_pkg::CMD_INSERT) ||
                      ((r_item.command == tkst_pkg::CMD_SUBMIT) &&
                       (r_item.new_score != 24'd0) && w_qual);
    assign w_ins    = w_do_ins && (|w_place);

    // Insertion cell to rank (at most one cell places)
    always_comb begin
        w_rank_enc = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (w_place[i]) begin
                w_rank_enc = w_rank_enc | CW'(i);
            end
        end
    end

    assign w_rank    = w_ins ? w_rank_enc : CW'(TABLE_DEPTH);
    assign w_new_cnt = (w_ins && (w_cnt < CW'(TABLE_DEPTH))) ? (w_cnt + CW'(1)) : w_cnt;
    assign w_top0    = (w_ins && w_place[0]) ? r_item.new_score : w_ent[0].score;

    assign w_res.qualifies   = w_qual;
    assign w_res.top_score   = ((w_new_cnt != '0) && (w_top0 > tkst_pkg::TOP_FLOOR)) ?
                               w_top0 : tkst_pkg::TOP_FLOOR;
    assign w_res.inserted    = w_ins;
    assign w_res.insert_rank = 4'(w_rank);
    assign w_res.entry_count = 4'(w_new_cnt);

    // Output register
    always_comb begin
        n_out_vld  = r_out_vld && i_out_stall;
        n_out_item = r_out_item;
        if (w_go) begin
            n_out_vld  = 1'b1;
            n_out_item = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_in_stall  = w_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    // A fresh result only comes out of the execute step
    a_out_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state) == tkst_pkg::ST_EXEC)
        else $error("result appeared without an execute step");

    // The new entry lands in at most one cell
    a_place_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tkst_pkg::ST_EXEC |-> $onehot0(w_place))
        else $error("more than one insertion point");

    // A board never holds more than its depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tkst_pkg::ST_EXEC |-> w_new_cnt <= CW'(TABLE_DEPTH))
        else $error("entry count beyond depth");

endmodule
